>>> rtl/ace_pkg.sv
// ace_pkg: shared types, widths, coefficients and rounding for the color adjuster
// used by every file in rtl/; depends on nothing
package ace_pkg;

	// number format: channels Q1.FRAC_BITS, gains Q2.FRAC_BITS
	localparam int FRAC_BITS = 12;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int HALF      = ONE / 2;

	localparam int CH_W    = FRAC_BITS + 1;      // channel, 0..2*ONE-1
	localparam int GAIN_W  = FRAC_BITS + 2;      // gain register
	localparam int COEF_W  = FRAC_BITS + 2;      // signed coefficient, holds ONE
	localparam int LUMA_W  = FRAC_BITS + 3;      // signed luma and its partials
	localparam int DIFF_W  = FRAC_BITS + 4;      // channel minus luma
	localparam int SAT_W   = FRAC_BITS + 5;      // after saturation
	localparam int TERM_W  = FRAC_BITS + 8;      // after contrast, matrix terms
	localparam int SUM_W   = FRAC_BITS + 9;      // matrix row sum
	localparam int PROD_W  = 2 * FRAC_BITS + 10; // widest product

	localparam int LANES    = 3;
	localparam int ROWS     = 3;
	localparam int PIPE_LAT = 6;

	// register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SAT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CON  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd2;

	// vision modes
	localparam int VM_W = 2;
	localparam logic [VM_W-1:0] VM_NONE   = 2'd0;
	localparam logic [VM_W-1:0] VM_PROTAN = 2'd1;
	localparam logic [VM_W-1:0] VM_DEUTAN = 2'd2;
	localparam logic [VM_W-1:0] VM_TRITAN = 2'd3;

	typedef struct packed {
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] alpha_in;
	} ace_pixel_t;

	typedef struct packed {
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic [CH_W-1:0] alpha_out;
	} ace_result_t;

	typedef struct packed {
		logic [GAIN_W-1:0] sat_gain;
		logic [GAIN_W-1:0] con_gain;
		logic [VM_W-1:0]   mode;
	} ace_cfg_t;

	typedef logic signed [COEF_W-1:0] ace_coef_t;
	typedef logic signed [LUMA_W-1:0] ace_luma_t;
	typedef logic signed [TERM_W-1:0] ace_term_t;

	// decimal constant in ten-thousandths, rounded to nearest in signed Q1.FRAC_BITS
	function automatic int coef(input int tenk);
		return (tenk * ONE + 5000) / 10000;
	endfunction

	localparam ace_coef_t LUMA_COEF [LANES] = '{
		ace_coef_t'(coef(2126)), ace_coef_t'(coef(7152)), ace_coef_t'(coef(722))
	};

	// rows are output channels, columns are input channels
	localparam ace_coef_t IDENT_M [ROWS][LANES] = '{
		'{ace_coef_t'(coef(10000)), ace_coef_t'(0), ace_coef_t'(0)},
		'{ace_coef_t'(0), ace_coef_t'(coef(10000)), ace_coef_t'(0)},
		'{ace_coef_t'(0), ace_coef_t'(0), ace_coef_t'(coef(10000))}
	};
	localparam ace_coef_t PROTAN_M [ROWS][LANES] = '{
		'{ace_coef_t'(coef(5670)), ace_coef_t'(coef(4330)), ace_coef_t'(0)},
		'{ace_coef_t'(coef(5580)), ace_coef_t'(coef(4420)), ace_coef_t'(0)},
		'{ace_coef_t'(0), ace_coef_t'(coef(2420)), ace_coef_t'(coef(7580))}
	};
	localparam ace_coef_t DEUTAN_M [ROWS][LANES] = '{
		'{ace_coef_t'(coef(6250)), ace_coef_t'(coef(3750)), ace_coef_t'(0)},
		'{ace_coef_t'(coef(7000)), ace_coef_t'(coef(3000)), ace_coef_t'(0)},
		'{ace_coef_t'(0), ace_coef_t'(coef(3000)), ace_coef_t'(coef(7000))}
	};
	localparam ace_coef_t TRITAN_M [ROWS][LANES] = '{
		'{ace_coef_t'(coef(9500)), ace_coef_t'(coef(500)), ace_coef_t'(0)},
		'{ace_coef_t'(coef(4330)), ace_coef_t'(coef(4750)), ace_coef_t'(coef(920))},
		'{ace_coef_t'(0), ace_coef_t'(coef(4750)), ace_coef_t'(coef(5250))}
	};

	function automatic ace_coef_t mat_coef(input logic [VM_W-1:0] mode,
		input logic [1:0] row, input logic [1:0] col);
		unique case (mode)
			VM_PROTAN: mat_coef = PROTAN_M[row][col];
			VM_DEUTAN: mat_coef = DEUTAN_M[row][col];
			VM_TRITAN: mat_coef = TRITAN_M[row][col];
			default:   mat_coef = IDENT_M[row][col];
		endcase
	endfunction

	// round to nearest, ties upward, then drop the fraction (arithmetic shift = floor)
	function automatic logic signed [PROD_W-1:0] round_q(input logic signed [PROD_W-1:0] p);
		return (p + PROD_W'(HALF)) >>> FRAC_BITS;
	endfunction

endpackage

>>> rtl/ace_regs.sv
// ace_regs: configuration register file (saturation, contrast, vision mode)
// depends on ace_pkg
module ace_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic [ace_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ace_pkg::GAIN_W-1:0]    cfg_data,
	output ace_pkg::ace_cfg_t             cfg
);
	import ace_pkg::*;

	ace_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sat_gain <= GAIN_W'(ONE);
			cfg_q.con_gain <= GAIN_W'(ONE);
			cfg_q.mode     <= VM_NONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SAT:  cfg_q.sat_gain <= cfg_data;
				REG_CON:  cfg_q.con_gain <= cfg_data;
				REG_MODE: cfg_q.mode     <= cfg_data[VM_W-1:0];
				default: ; // unused index, write dropped
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/ace_lane.sv
// ace_lane: one color channel through luma partial, saturation, contrast
// and its column of the vision matrix; depends on ace_pkg
module ace_lane #(
	parameter int LANE = 0
) (
	input  logic                    clk,
	input  logic [ace_pkg::CH_W-1:0] chan,
	input  ace_pkg::ace_luma_t       luma_sum,
	input  ace_pkg::ace_cfg_t        cfg,
	output ace_pkg::ace_luma_t       luma_part_s1,
	output ace_pkg::ace_term_t       col_s5 [ace_pkg::ROWS]
);
	import ace_pkg::*;

	localparam logic [1:0] COL = 2'(LANE);

	logic [CH_W-1:0]          chan_s1;
	ace_luma_t                luma_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic signed [SAT_W-1:0]  sat_s3;
	ace_term_t                con_s4;

	logic signed [PROD_W-1:0] luma_p, sat_p, con_p;
	logic signed [PROD_W-1:0] luma_r, sat_r, con_r;
	logic signed [PROD_W-1:0] mat_p [ROWS];
	logic signed [PROD_W-1:0] mat_r [ROWS];
	logic signed [SAT_W-1:0]  centered;

	always_comb begin
		luma_p   = $signed({1'b0, chan}) * LUMA_COEF[COL];
		luma_r   = round_q(luma_p);
		sat_p    = diff_s2 * $signed({1'b0, cfg.sat_gain});
		sat_r    = round_q(sat_p);
		centered = sat_s3 - SAT_W'(HALF);
		con_p    = centered * $signed({1'b0, cfg.con_gain});
		con_r    = round_q(con_p);
		for (int j = 0; j < ROWS; j++) begin
			mat_p[j] = con_s4 * mat_coef(cfg.mode, 2'(j), COL);
			mat_r[j] = round_q(mat_p[j]);
		end
	end

	always_ff @(posedge clk) begin
		// s1: luma partial product
		chan_s1      <= chan;
		luma_part_s1 <= luma_r[LUMA_W-1:0];
		// s2: distance from luma
		luma_s2      <= luma_sum;
		diff_s2      <= DIFF_W'($signed({1'b0, chan_s1})) - DIFF_W'(luma_sum);
		// s3: saturation
		sat_s3       <= SAT_W'(luma_s2) + sat_r[SAT_W-1:0];
		// s4: contrast about mid-grey
		con_s4       <= con_r[TERM_W-1:0] + TERM_W'(HALF);
		// s5: this channel's column of the matrix
		for (int j = 0; j < ROWS; j++) begin
			col_s5[j] <= mat_r[j][TERM_W-1:0];
		end
	end

endmodule

>>> rtl/ace_merge.sv
// ace_merge: sums the lanes' matrix terms per output channel, clamps, registers
// depends on ace_pkg
module ace_merge (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_s5,
	input  logic [ace_pkg::CH_W-1:0] alpha_s5,
	input  ace_pkg::ace_term_t       terms [ace_pkg::LANES][ace_pkg::ROWS],
	output ace_pkg::ace_result_t     result,
	output logic                     done
);
	import ace_pkg::*;

	logic signed [SUM_W-1:0] row_sum [ROWS];
	logic [CH_W-1:0]         row_clamp [ROWS];
	logic [CH_W-1:0]         alpha_clamp;
	ace_result_t             result_q;
	logic                    done_q;

	always_comb begin
		for (int j = 0; j < ROWS; j++) begin
			row_sum[j] = SUM_W'(terms[0][j]) + SUM_W'(terms[1][j]) + SUM_W'(terms[2][j]);
			if (row_sum[j] < 0) begin
				row_clamp[j] = '0;
			end else if (row_sum[j] > SUM_W'(ONE)) begin
				row_clamp[j] = CH_W'(ONE);
			end else begin
				row_clamp[j] = row_sum[j][CH_W-1:0];
			end
		end
		alpha_clamp = (alpha_s5 > CH_W'(ONE)) ? CH_W'(ONE) : alpha_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		result_q.red_out   <= row_clamp[0];
		result_q.green_out <= row_clamp[1];
		result_q.blue_out  <= row_clamp[2];
		result_q.alpha_out <= alpha_clamp;
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

>>> rtl/accessibility_color_adjust.sv
// accessibility_color_adjust: top level of the saturation / contrast / vision adjuster
// depends on ace_pkg, ace_regs, ace_lane, ace_merge
//
// One RGBA color is taken on every clock at which start is high; busy never
// rises, so a new color may follow in the very next cycle. Each color comes
// back on result with done high for one cycle, in the order taken; the
// result is not held, so the receiver must take it in that cycle. Its path
// runs through the registered pipeline: luma partials, luma difference,
// saturation multiply, contrast multiply, matrix multiplies, then the merge
// with clamp. The configuration registers (saturation gain, contrast gain,
// vision mode) are written over the cfg channel, which is always ready;
// write them only while no color is in flight.
module accessibility_color_adjust (
	input  logic                          clk,
	input  logic                          arst_n,
	// color channel
	input  logic                          start,
	output logic                          busy,
	input  ace_pkg::ace_pixel_t           pixel,
	output logic                          done,
	output ace_pkg::ace_result_t          result,
	// configuration channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ace_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ace_pkg::GAIN_W-1:0]    cfg_data
);
	import ace_pkg::*;

	ace_cfg_t  cfg;
	logic      accept;

	// per-lane channel values, luma partials and matrix columns
	logic [CH_W-1:0]       chan_in [LANES];
	ace_luma_t             luma_part [LANES];
	logic signed [LUMA_W+1:0] luma_wide;
	ace_luma_t             luma_sum;
	ace_term_t             terms [LANES][ROWS];

	// valid and alpha ride alongside the lanes
	logic            valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic [CH_W-1:0] alpha_s1, alpha_s2, alpha_s3, alpha_s4, alpha_s5;

	// pipeline never backs up, one color per clock
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	ace_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign chan_in[0] = pixel.red_in;
	assign chan_in[1] = pixel.green_in;
	assign chan_in[2] = pixel.blue_in;

	// luma is the one cross-lane value before the matrix; summed here and fed back
	assign luma_wide = (LUMA_W+2)'(luma_part[0]) + (LUMA_W+2)'(luma_part[1])
		+ (LUMA_W+2)'(luma_part[2]);
	assign luma_sum  = luma_wide[LUMA_W-1:0];

	for (genvar k = 0; k < LANES; k++) begin : g_lane
		ace_lane #(
			.LANE (k)
		) u_lane (
			.clk          (clk),
			.chan         (chan_in[k]),
			.luma_sum     (luma_sum),
			.cfg          (cfg),
			.luma_part_s1 (luma_part[k]),
			.col_s5       (terms[k])
		);
	end

	// valid tracking, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// alpha only needs delay to line up with the lanes
	always_ff @(posedge clk) begin
		alpha_s1 <= pixel.alpha_in;
		alpha_s2 <= alpha_s1;
		alpha_s3 <= alpha_s2;
		alpha_s4 <= alpha_s3;
		alpha_s5 <= alpha_s4;
	end

	ace_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s5 (valid_s5),
		.alpha_s5 (alpha_s5),
		.terms    (terms),
		.result   (result),
		.done     (done)
	);

endmodule

>>> rtl/ace_check.sv
// ace_check: port-level checks on latency, output range and alpha transfer
// depends on ace_pkg; bound to accessibility_color_adjust below
module ace_check (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input ace_pkg::ace_pixel_t  pixel,
	input logic                 done,
	input ace_pkg::ace_result_t result
);
	import ace_pkg::*;

	// every transfer in comes back after the fixed latency
	a_latency_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("transfer in without result after pipeline latency");

	// no result without a transfer in at the matching cycle
	a_latency_in: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result without matching transfer in");

	// every channel lands in [0, 1.0]
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.red_out <= CH_W'(ONE)) && (result.green_out <= CH_W'(ONE))
			&& (result.blue_out <= CH_W'(ONE)) && (result.alpha_out <= CH_W'(ONE)))
		else $error("result channel above 1.0");

	// alpha is the input alpha, clamped
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.alpha_out == (($past(pixel.alpha_in, PIPE_LAT) > CH_W'(ONE))
			? CH_W'(ONE) : $past(pixel.alpha_in, PIPE_LAT)))
		else $error("alpha not carried through");

endmodule

bind accessibility_color_adjust ace_check u_ace_check (.*);

>>> tb/tb_accessibility_color_adjust.sv
// tb_accessibility_color_adjust: self-checking testbench for the color adjuster
// depends on ace_pkg and accessibility_color_adjust from rtl/
`timescale 1ns / 1ps

module tb_accessibility_color_adjust;
	import ace_pkg::*;

	// unused register slot, writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_COLORS  = 100;

	typedef enum logic {OP_COLOR, OP_WRITE} op_kind_e;

	// one pending stimulus step: a color transfer or a register write
	typedef struct {
		op_kind_e              kind;
		ace_pixel_t            px;
		logic [CFG_IDX_W-1:0]  idx;
		logic [GAIN_W-1:0]     data;
		int unsigned           gap;
	} pending_op_t;

	// dut ports, inputs known from time zero
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	ace_pixel_t           pixel = '0;
	logic                 done;
	ace_result_t          result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SAT;
	logic [GAIN_W-1:0]    cfg_data = '0;

	pending_op_t pending_ops[$];
	ace_result_t awaited_colors[$];

	int errors = 0;
	int colors_checked = 0;
	int reg_writes = 0;
	int config_phases = 0;
	int mode_hits [4] = '{0, 0, 0, 0};
	int cycles = 0;

	accessibility_color_adjust DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.pixel    (pixel),
		.done     (done),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// color predictor, Q1.12 channels and Q2.12 gains in 64-bit signed
	// ------------------------------------------------------------------

	// decimal constant in ten-thousandths to Q0.12, rounded to nearest
	function automatic longint to_q12(input longint tenk);
		return (tenk * ONE + 5000) / 10000;
	endfunction

	// fixed-point product, round half up; >>> on a signed value is a floor
	function automatic longint q_mul(input longint a, input longint b);
		return (a * b + HALF) >>> FRAC_BITS;
	endfunction

	function automatic logic [CH_W-1:0] to_unit(input longint v);
		if (v < 0)
			return '0;
		if (v > ONE)
			return CH_W'(ONE);
		return CH_W'(v);
	endfunction

	function automatic ace_result_t predict_color(input ace_pixel_t px,
		input logic [GAIN_W-1:0] sat, input logic [GAIN_W-1:0] con,
		input logic [VM_W-1:0] mode);
		longint ch [3];
		longint t [3];
		longint m [3];
		longint luma;
		longint s;
		ace_result_t r;
		ch[0] = px.red_in;
		ch[1] = px.green_in;
		ch[2] = px.blue_in;
		// rec.709 luma, each term rounded on its own
		luma = q_mul(ch[0], to_q12(2126)) + q_mul(ch[1], to_q12(7152))
			+ q_mul(ch[2], to_q12(722));
		// saturation away from luma, then contrast about mid-grey
		for (int k = 0; k < 3; k++) begin
			s = luma + q_mul(ch[k] - luma, longint'(sat));
			t[k] = q_mul(s - HALF, longint'(con)) + HALF;
		end
		case (mode)
			VM_PROTAN: begin
				m[0] = q_mul(t[0], to_q12(5670)) + q_mul(t[1], to_q12(4330));
				m[1] = q_mul(t[0], to_q12(5580)) + q_mul(t[1], to_q12(4420));
				m[2] = q_mul(t[1], to_q12(2420)) + q_mul(t[2], to_q12(7580));
			end
			VM_DEUTAN: begin
				m[0] = q_mul(t[0], to_q12(6250)) + q_mul(t[1], to_q12(3750));
				m[1] = q_mul(t[0], to_q12(7000)) + q_mul(t[1], to_q12(3000));
				m[2] = q_mul(t[1], to_q12(3000)) + q_mul(t[2], to_q12(7000));
			end
			VM_TRITAN: begin
				m[0] = q_mul(t[0], to_q12(9500)) + q_mul(t[1], to_q12(500));
				m[1] = q_mul(t[0], to_q12(4330)) + q_mul(t[1], to_q12(4750))
					+ q_mul(t[2], to_q12(920));
				m[2] = q_mul(t[1], to_q12(4750)) + q_mul(t[2], to_q12(5250));
			end
			default: begin
				m[0] = t[0];
				m[1] = t[1];
				m[2] = t[2];
			end
		endcase
		r.red_out   = to_unit(m[0]);
		r.green_out = to_unit(m[1]);
		r.blue_out  = to_unit(m[2]);
		// alpha only goes through the clamp
		r.alpha_out = to_unit(longint'(px.alpha_in));
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want_v);
		$display("ERROR at %0t: %s: got %0d, want %0d", $time, what, got, want_v);
		errors++;
	endtask

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------

	function automatic int unsigned draw_gap(input bit no_idle);
		return no_idle ? 0 : $urandom_range(0, 14);
	endfunction

	// mostly in-range channels, some pinned to the ends, some above 1.0
	function automatic logic [CH_W-1:0] rand_channel();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return $urandom_range(0, 1) ? CH_W'(ONE) : '0;
		if (pick == 1)
			return CH_W'($urandom_range(0, (1 << CH_W) - 1));
		return CH_W'($urandom_range(0, ONE));
	endfunction

	task automatic add_color(input int r, input int g, input int b, input int a,
		input int unsigned gap);
		pending_op_t op;
		op.kind = OP_COLOR;
		op.px.red_in   = CH_W'(r);
		op.px.green_in = CH_W'(g);
		op.px.blue_in  = CH_W'(b);
		op.px.alpha_in = CH_W'(a);
		op.idx  = REG_SAT;
		op.data = '0;
		op.gap  = gap;
		pending_ops = {pending_ops, op};
	endtask

	// a write waits for the pipeline to drain before it goes out
	task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input int data);
		pending_op_t op;
		op.kind = OP_WRITE;
		op.px   = '0;
		op.idx  = idx;
		op.data = GAIN_W'(data);
		op.gap  = 0;
		pending_ops = {pending_ops, op};
	endtask

	// ------------------------------------------------------------------
	// driver: one color or one register write at a time from the queue
	// ------------------------------------------------------------------

	int  colors_in_flight = 0;
	int unsigned wait_cnt = 0;
	bit  gap_armed = 1'b0;
	bit  start_nxt;
	bit  valid_nxt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			pixel     <= '0;
			cfg_valid <= 1'b0;
			cfg_index <= REG_SAT;
			cfg_data  <= '0;
			colors_in_flight = 0;
			wait_cnt  = 0;
			gap_armed = 1'b0;
		end else begin
			// own count of colors in the pipe, from this edge's transfers
			if (start && !busy)
				colors_in_flight++;
			if (done)
				colors_in_flight--;
			// anything offered and not yet taken stays up
			start_nxt = start && busy;
			valid_nxt = cfg_valid && !cfg_ready;
			if (!start_nxt && !valid_nxt && pending_ops.size() != 0) begin
				if (!gap_armed) begin
					wait_cnt  = pending_ops[0].gap;
					gap_armed = 1'b1;
				end
				if (wait_cnt != 0) begin
					wait_cnt--;
				end else if (pending_ops[0].kind == OP_COLOR) begin
					pixel <= pending_ops[0].px;
					start_nxt = 1'b1;
					void'(pending_ops.pop_front());
					gap_armed = 1'b0;
				end else if (colors_in_flight == 0) begin
					// registers only change with the pipe empty
					cfg_index <= pending_ops[0].idx;
					cfg_data  <= pending_ops[0].data;
					valid_nxt = 1'b1;
					void'(pending_ops.pop_front());
					gap_armed = 1'b0;
				end
			end
			start     <= start_nxt;
			cfg_valid <= valid_nxt;
		end
	end

	// ------------------------------------------------------------------
	// monitor: tracks register writes, predicts on each color transfer and
	// checks each done strobe against the oldest prediction
	// ------------------------------------------------------------------

	logic [GAIN_W-1:0] sat_shadow;
	logic [GAIN_W-1:0] con_shadow;
	logic [VM_W-1:0]   mode_shadow;
	ace_result_t       oldest;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_shadow  = GAIN_W'(ONE);
			con_shadow  = GAIN_W'(ONE);
			mode_shadow = VM_NONE;
		end else begin
			if (done) begin
				if (awaited_colors.size() == 0) begin
					report_mismatch("result with no color outstanding, red_out",
						result.red_out, 0);
				end else begin
					oldest = awaited_colors.pop_front();
					if (result.red_out !== oldest.red_out)
						report_mismatch("red_out", result.red_out, oldest.red_out);
					if (result.green_out !== oldest.green_out)
						report_mismatch("green_out", result.green_out, oldest.green_out);
					if (result.blue_out !== oldest.blue_out)
						report_mismatch("blue_out", result.blue_out, oldest.blue_out);
					if (result.alpha_out !== oldest.alpha_out)
						report_mismatch("alpha_out", result.alpha_out, oldest.alpha_out);
					colors_checked++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				reg_writes++;
				case (cfg_index)
					REG_SAT:  sat_shadow  = cfg_data;
					REG_CON:  con_shadow  = cfg_data;
					REG_MODE: mode_shadow = cfg_data[VM_W-1:0];
					default:  ; // unused slot, nothing changes
				endcase
			end
			if (start && !busy) begin
				awaited_colors = {awaited_colors, predict_color(pixel, sat_shadow,
					con_shadow, mode_shadow)};
				mode_hits[mode_shadow]++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d colors still outstanding",
				cycles, awaited_colors.size());
			$display("accessibility_color_adjust test failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// sequence: directed corners, then random phases, then drain
	// ------------------------------------------------------------------

	initial begin
		bit no_idle;
		int sat_v;
		int con_v;

		// reset settings: unit gains, no vision filter
		config_phases++;
		add_color(0, 0, 0, 0, draw_gap(1'b0));
		add_color(ONE, ONE, ONE, ONE, draw_gap(1'b0));
		add_color(8191, 8191, 8191, 8191, draw_gap(1'b0));   // every channel above 1.0
		add_color(ONE, 0, 0, ONE, draw_gap(1'b0));
		add_color(0, ONE, 0, ONE, draw_gap(1'b0));
		add_color(0, 0, ONE, ONE, draw_gap(1'b0));
		add_color(HALF, HALF, HALF, HALF, draw_gap(1'b0));   // mid-grey is a fixed point
		add_color(0, 0, 0, 8191, draw_gap(1'b0));            // alpha clamped down
		add_color(1, ONE - 1, ONE + 1, ONE + 1, draw_gap(1'b0));

		// top gains, protanopia, junk in the upper mode bits
		config_phases++;
		add_write(REG_SAT, 8192);
		add_write(REG_CON, 8192);
		add_write(REG_MODE, (16'h3ffc | VM_PROTAN));
		add_color(ONE, 0, 0, ONE, draw_gap(1'b0));
		add_color(ONE, ONE, ONE, 0, draw_gap(1'b0));
		add_color(8191, 0, ONE, HALF, draw_gap(1'b0));
		add_color(1000, 3000, 500, ONE, draw_gap(1'b0));

		// bottom gains, tritanopia: fully desaturated, low contrast
		config_phases++;
		add_write(REG_SAT, 0);
		add_write(REG_CON, 2048);
		add_write(REG_MODE, VM_TRITAN);
		add_color(ONE, 0, 0, ONE, draw_gap(1'b0));
		add_color(0, ONE, ONE, ONE, draw_gap(1'b0));
		add_color(8191, 8191, 0, 0, draw_gap(1'b0));

		// gains outside the stated ranges, contrast below 0.5 taken as is
		config_phases++;
		add_write(REG_SAT, 16383);
		add_write(REG_CON, 0);
		add_write(REG_MODE, VM_DEUTAN);
		add_color(ONE, HALF, 0, ONE, draw_gap(1'b0));
		add_color(123, 4000, 2500, ONE, draw_gap(1'b0));
		add_color(8191, 0, 8191, 8191, draw_gap(1'b0));

		// write to the unused slot must be ignored
		config_phases++;
		add_write(REG_UNUSED, 16383);
		add_write(REG_CON, 16383);
		add_write(REG_MODE, VM_NONE);
		add_color(3000, 1000, 2000, ONE, draw_gap(1'b0));
		add_color(0, 8191, 0, 1, draw_gap(1'b0));

		// random phases, each with fresh register values
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			config_phases++;
			no_idle = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0:       sat_v = 0;
				1:       sat_v = 8192;
				2:       sat_v = 16383;
				3:       sat_v = ONE;
				4:       sat_v = $urandom_range(0, 16383);
				default: sat_v = $urandom_range(0, 8192);
			endcase
			case ($urandom_range(0, 5))
				0:       con_v = 2048;
				1:       con_v = 8192;
				2:       con_v = $urandom_range(0, 2047);
				3:       con_v = $urandom_range(0, 16383);
				default: con_v = $urandom_range(2048, 8192);
			endcase
			if ($urandom_range(0, 2) == 0)
				add_write(REG_UNUSED, $urandom_range(0, 16383));
			add_write(REG_SAT, sat_v);
			add_write(REG_CON, con_v);
			add_write(REG_MODE, $urandom_range(0, 16383));
			for (int i = 0; i < PHASE_COLORS; i++)
				add_color(rand_channel(), rand_channel(), rand_channel(), rand_channel(),
					draw_gap(no_idle));
		end

		// reset held from time zero, released on a rising edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// everything sent, then everything back, then let the pipe run dry
		while (pending_ops.size() != 0 || start || cfg_valid)
			@(posedge clk);
		while (awaited_colors.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4) @(posedge clk);

		$display("checked %0d colors across %0d register settings (%0d register transfers)",
			colors_checked, config_phases, reg_writes);
		$display("colors per vision mode: none %0d, protan %0d, deutan %0d, tritan %0d",
			mode_hits[VM_NONE], mode_hits[VM_PROTAN], mode_hits[VM_DEUTAN],
			mode_hits[VM_TRITAN]);
		if (errors == 0) begin
			$display("accessibility_color_adjust test passed");
		end else begin
			$display("%0d mismatches", errors);
			$display("accessibility_color_adjust test failed");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/ace_pkg.sv
rtl/ace_regs.sv
rtl/ace_lane.sv
rtl/ace_merge.sv
rtl/accessibility_color_adjust.sv
rtl/ace_check.sv
tb/tb_accessibility_color_adjust.sv
